// ----- src/round_robin_cpu_scheduler_unit_defines.svh -----
// assertion macros for the round robin scheduler
// no dependencies
`ifndef ROUND_ROBIN_CPU_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_CPU_SCHEDULER_UNIT_DEFINES_SVH

// antecedent holds in a cycle, consequent in the same cycle
`define RRCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle, consequent in the next cycle
`define RRCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rrcs_pkg.sv -----
// shared types and codes of the round robin scheduler
// no dependencies
package rrcs_pkg;

    localparam int TIME_W = 21;
    localparam int FIELD_W = 16;
    localparam int PID_W = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [FIELD_W-1:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic idle;
        logic clear;
        logic set_full;
        logic set_empty;
        logic scan_reset;
        logic scan_inc;
        logic insert;
        logic addr_scan;
        logic addr_first;
        logic jump;
        logic pop;
        logic run;
        logic fin_calc;
        logic admit_push;
        logic set_send;
        logic requeue;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic req_valid;
        logic [1:0] op;
        logic full;
        logic all_done;
        logic ring_empty;
        logic find_stop;
        logic scan_end;
        logic admit_ok;
        logic fin;
        logic out_free;
    } stat_t;

endpackage

// ----- src/rrcs_req_if.sv -----
// request channel of the scheduler
// depends on rrcs_pkg
interface rrcs_req_if;
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [rrcs_pkg::FIELD_W-1:0] arrival_time;
    logic [rrcs_pkg::FIELD_W-1:0] burst_time;

    modport source (output valid, output operation, output arrival_time,
                    output burst_time, input ready);
    modport sink (input valid, input operation, input arrival_time,
                  input burst_time, output ready);
endinterface

// ----- src/rrcs_rsp_if.sv -----
// result channel of the scheduler
// depends on rrcs_pkg
interface rrcs_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [rrcs_pkg::PID_W-1:0] process_id;
    logic [rrcs_pkg::TIME_W-1:0] slice_end_time;
    logic finished;
    logic [rrcs_pkg::TIME_W-1:0] waiting_time;
    logic [rrcs_pkg::TIME_W-1:0] turnaround_time;
    logic all_done;

    modport source (output valid, output status, output process_id,
                    output slice_end_time, output finished, output waiting_time,
                    output turnaround_time, output all_done, input ready);
    modport sink (input valid, input status, input process_id,
                  input slice_end_time, input finished, input waiting_time,
                  input turnaround_time, input all_done, output ready);
endinterface

// ----- src/round_robin_cpu_scheduler_unit.sv -----
// round robin scheduler with a time quantum, top level
// add: decode, scan past the n table entries ahead of the insert point, insert
// dispatch: decode, jump if ring empty, pop, run, fin, arrival scan, requeue if unfinished
// clear, full add, empty dispatch and unused codes: decode, then done; a new request is
// taken the cycle after the result register loads, which waits while it is held
// rst_n clears table, ring, clock and sets the quantum to 4
module round_robin_cpu_scheduler_unit
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        time_quantum_we,
    input  logic [15:0] time_quantum_wdata,
    rrcs_req_if.sink    in_req,
    rrcs_rsp_if.source  out_rsp
);

    rrcs_pkg::cmd_t cmd;
    rrcs_pkg::stat_t stat;

    rrcs_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    rrcs_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (time_quantum_we),
        .cfg_wdata (time_quantum_wdata),
        .req       (in_req),
        .rsp       (out_rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- src/rrcs_controller.sv -----
// sequencer of the round robin scheduler
// depends on rrcs_pkg
module rrcs_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  rrcs_pkg::stat_t stat,
    output rrcs_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_FIND   = 4'd2;
    localparam logic [3:0] S_INSERT = 4'd3;
    localparam logic [3:0] S_JUMP   = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_RUN    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_ADMIT  = 4'd8;
    localparam logic [3:0] S_REQ    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.op)
                    rrcs_pkg::OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    rrcs_pkg::OP_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_reset = 1'b1;
                            state_next = S_FIND;
                        end
                    end
                    rrcs_pkg::OP_DISPATCH:
                    begin
                        if (stat.all_done)
                        begin
                            cmd.set_empty = 1'b1;
                        end
                        else if (stat.ring_empty)
                        begin
                            state_next = S_JUMP;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FIND:
            begin
                cmd.addr_scan = 1'b1;
                if (stat.scan_end || stat.find_stop)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_JUMP:
            begin
                cmd.addr_first = 1'b1;
                cmd.jump = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.run = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin_calc = 1'b1;
                cmd.scan_reset = 1'b1;
                state_next = S_ADMIT;
            end
            S_ADMIT:
            begin
                cmd.addr_scan = 1'b1;
                if (stat.scan_end)
                begin
                    cmd.set_send = 1'b1;
                    state_next = stat.fin ? S_DONE : S_REQ;
                end
                else
                begin
                    cmd.admit_push = stat.admit_ok;
                    cmd.scan_inc = 1'b1;
                end
            end
            S_REQ:
            begin
                cmd.requeue = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rrcs_datapath.sv -----
// process table, ready ring, clock and result registers of the scheduler
// depends on rrcs_pkg, rrcs_req_if, rrcs_rsp_if and the defines header
`include "round_robin_cpu_scheduler_unit_defines.svh"

module rrcs_datapath
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    rrcs_req_if.sink          req,
    rrcs_rsp_if.source        rsp,
    input  rrcs_pkg::cmd_t    cmd,
    output rrcs_pkg::stat_t   stat
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int TW = rrcs_pkg::TIME_W;
    localparam int FW = rrcs_pkg::FIELD_W;
    localparam int PW = rrcs_pkg::PID_W;

    logic [FW-1:0] arr_reg [MAX_PROCS];
    logic [FW-1:0] burst_reg [MAX_PROCS];
    logic [FW-1:0] rem_reg [MAX_PROCS];
    logic [CW-1:0] lo_reg [MAX_PROCS];
    logic [IW-1:0] ring_reg [MAX_PROCS];
    logic [MAX_PROCS-1:0] comp_reg;
    logic [MAX_PROCS-1:0] queued_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] tail_reg;
    logic [CW-1:0] ring_count_reg;
    logic [CW-1:0] pcount_reg;
    logic [TW-1:0] time_reg;
    logic [FW-1:0] quantum_reg;
    logic [CW-1:0] scan_reg;
    logic [IW-1:0] cur_reg;
    logic fin_reg;

    logic [1:0] op_reg;
    logic [FW-1:0] at_reg;
    logic [FW-1:0] bt_reg;

    logic [1:0] rs_status_reg;
    logic [PW-1:0] rs_pid_reg;
    logic [TW-1:0] rs_send_reg;
    logic rs_fin_reg;
    logic [TW-1:0] rs_wt_reg;
    logic [TW-1:0] rs_tt_reg;

    logic out_valid_reg;
    logic [1:0] out_status_reg;
    logic [PW-1:0] out_pid_reg;
    logic [TW-1:0] out_send_reg;
    logic out_fin_reg;
    logic [TW-1:0] out_wt_reg;
    logic [TW-1:0] out_tt_reg;
    logic out_done_reg;

    logic [IW-1:0] first_idx;
    logic [IW-1:0] rd_idx;
    logic [FW-1:0] rd_arr;
    logic [FW-1:0] rd_burst;
    logic [FW-1:0] rd_rem;
    logic [CW-1:0] rd_lo;
    logic [FW-1:0] q;
    logic [MAX_PROCS-1:0] mask;
    logic all_done;
    logic accept;
    logic push_en;
    logic [IW-1:0] push_idx;
    logic [IW-1:0] pop_raw;
    logic [IW-1:0] pop_idx;
    logic remain_le_q;
    logic [TW:0] run_sum;
    logic [TW-1:0] run_time;
    logic [FW:0] ab_sum;
    logic [IW-1:0] tail_inc;
    logic [IW-1:0] head_inc;

    always_comb
    begin
        first_idx = '0;
        for (int k = MAX_PROCS - 1; k >= 0; k--)
        begin
            if (!comp_reg[k])
            begin
                first_idx = IW'(k);
            end
        end
        for (int k = 0; k < MAX_PROCS; k++)
        begin
            mask[k] = CW'(k) < pcount_reg;
        end
    end

    assign all_done = &(comp_reg | ~mask);
    assign accept = req.valid && cmd.idle;
    assign rd_idx = cmd.addr_scan ? scan_reg[IW-1:0] : (cmd.addr_first ? first_idx : cur_reg);
    assign rd_arr = arr_reg[rd_idx];
    assign rd_burst = burst_reg[rd_idx];
    assign rd_rem = rem_reg[rd_idx];
    assign rd_lo = lo_reg[rd_idx];
    assign q = (quantum_reg == '0) ? FW'(1) : quantum_reg;
    assign remain_le_q = rd_rem <= q;
    assign run_sum = {1'b0, time_reg} + (TW + 1)'(remain_le_q ? rd_rem : q);
    assign run_time = (run_sum > (TW + 1)'(rrcs_pkg::TIME_MAX)) ? rrcs_pkg::TIME_MAX
                                                               : run_sum[TW-1:0];
    assign ab_sum = {1'b0, rd_arr} + {1'b0, rd_burst};
    assign pop_raw = ring_reg[head_reg];
    assign pop_idx = (CW'(pop_raw) >= pcount_reg) ? '0 : pop_raw;
    assign tail_inc = ((CW + 1)'(tail_reg) + 1'b1 >= (CW + 1)'(MAX_PROCS)) ? '0
                                                                          : tail_reg + 1'b1;
    assign head_inc = ((CW + 1)'(head_reg) + 1'b1 >= (CW + 1)'(MAX_PROCS)) ? '0
                                                                          : head_reg + 1'b1;

    always_comb
    begin
        push_en = 1'b0;
        push_idx = cur_reg;
        if (cmd.jump)
        begin
            push_en = 1'b1;
            push_idx = first_idx;
        end
        else if (cmd.admit_push)
        begin
            push_en = 1'b1;
            push_idx = scan_reg[IW-1:0];
        end
        else if (cmd.requeue)
        begin
            push_en = 1'b1;
        end
        if (ring_count_reg >= CW'(MAX_PROCS))
        begin
            push_en = 1'b0;
        end
    end

    always_comb
    begin
        stat.req_valid = req.valid;
        stat.op = op_reg;
        stat.full = pcount_reg >= CW'(MAX_PROCS);
        stat.all_done = all_done;
        stat.ring_empty = ring_count_reg == '0;
        stat.find_stop = rd_arr > at_reg;
        stat.scan_end = scan_reg == pcount_reg;
        stat.admit_ok = (TW'(rd_arr) <= time_reg) && !comp_reg[rd_idx]
                        && !queued_reg[rd_idx] && (rd_idx != cur_reg);
        stat.fin = fin_reg;
        stat.out_free = !out_valid_reg || rsp.ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg <= '0;
            queued_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            ring_count_reg <= '0;
            pcount_reg <= '0;
            time_reg <= '0;
            quantum_reg <= rrcs_pkg::QUANTUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear)
            begin
                comp_reg <= '0;
                queued_reg <= '0;
                head_reg <= '0;
                tail_reg <= '0;
                ring_count_reg <= '0;
                pcount_reg <= '0;
                time_reg <= '0;
            end
            if (cmd.insert)
            begin
                for (int k = 1; k < MAX_PROCS; k++)
                begin
                    if (CW'(k) > scan_reg && CW'(k) <= pcount_reg)
                    begin
                        comp_reg[k] <= comp_reg[k-1];
                        queued_reg[k] <= queued_reg[k-1];
                    end
                end
                comp_reg[scan_reg[IW-1:0]] <= 1'b0;
                queued_reg[scan_reg[IW-1:0]] <= 1'b0;
                pcount_reg <= pcount_reg + 1'b1;
            end
            if (cmd.jump && TW'(rd_arr) > time_reg)
            begin
                time_reg <= TW'(rd_arr);
            end
            if (cmd.pop)
            begin
                head_reg <= head_inc;
                ring_count_reg <= ring_count_reg - 1'b1;
                if (CW'(pop_raw) < CW'(MAX_PROCS))
                begin
                    queued_reg[pop_raw] <= 1'b0;
                end
            end
            if (cmd.run)
            begin
                time_reg <= run_time;
                if (remain_le_q)
                begin
                    comp_reg[cur_reg] <= 1'b1;
                end
            end
            if (push_en)
            begin
                tail_reg <= tail_inc;
                ring_count_reg <= ring_count_reg + 1'b1;
                queued_reg[push_idx] <= 1'b1;
            end
        end
    end

    // tables, ring slots and payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.operation;
            at_reg <= req.arrival_time;
            bt_reg <= req.burst_time;
            rs_status_reg <= rrcs_pkg::ST_OK;
            rs_pid_reg <= '0;
            rs_send_reg <= '0;
            rs_fin_reg <= 1'b0;
            rs_wt_reg <= '0;
            rs_tt_reg <= '0;
        end
        if (cmd.set_full)
        begin
            rs_status_reg <= rrcs_pkg::ST_FULL;
        end
        if (cmd.set_empty)
        begin
            rs_status_reg <= rrcs_pkg::ST_EMPTY;
        end
        if (cmd.scan_reset)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.insert)
        begin
            for (int k = 1; k < MAX_PROCS; k++)
            begin
                if (CW'(k) > scan_reg && CW'(k) <= pcount_reg)
                begin
                    arr_reg[k] <= arr_reg[k-1];
                    burst_reg[k] <= burst_reg[k-1];
                    rem_reg[k] <= rem_reg[k-1];
                    lo_reg[k] <= lo_reg[k-1];
                end
            end
            for (int k = 0; k < MAX_PROCS; k++)
            begin
                if (CW'(ring_reg[k]) >= scan_reg
                    && (CW + 1)'(ring_reg[k]) + 1'b1 < (CW + 1)'(MAX_PROCS))
                begin
                    ring_reg[k] <= ring_reg[k] + 1'b1;
                end
            end
            arr_reg[scan_reg[IW-1:0]] <= at_reg;
            burst_reg[scan_reg[IW-1:0]] <= bt_reg;
            rem_reg[scan_reg[IW-1:0]] <= bt_reg;
            lo_reg[scan_reg[IW-1:0]] <= pcount_reg + 1'b1;
            rs_pid_reg <= PW'(pcount_reg + 1'b1);
        end
        if (cmd.pop)
        begin
            cur_reg <= pop_idx;
        end
        if (cmd.run)
        begin
            rs_pid_reg <= PW'(rd_lo);
            fin_reg <= remain_le_q;
            rs_fin_reg <= remain_le_q;
            rem_reg[cur_reg] <= remain_le_q ? '0 : rd_rem - q;
        end
        if (cmd.fin_calc && fin_reg)
        begin
            rs_wt_reg <= (time_reg >= TW'(ab_sum)) ? time_reg - TW'(ab_sum) : '0;
            rs_tt_reg <= (time_reg >= TW'(rd_arr)) ? time_reg - TW'(rd_arr) : '0;
        end
        if (cmd.set_send)
        begin
            rs_send_reg <= time_reg;
        end
        if (push_en)
        begin
            ring_reg[tail_reg] <= push_idx;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= rs_status_reg;
            out_pid_reg <= rs_pid_reg;
            out_send_reg <= rs_send_reg;
            out_fin_reg <= rs_fin_reg;
            out_wt_reg <= rs_wt_reg;
            out_tt_reg <= rs_tt_reg;
            out_done_reg <= all_done;
        end
    end

    assign req.ready = cmd.idle;
    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.process_id = out_pid_reg;
    assign rsp.slice_end_time = out_send_reg;
    assign rsp.finished = out_fin_reg;
    assign rsp.waiting_time = out_wt_reg;
    assign rsp.turnaround_time = out_tt_reg;
    assign rsp.all_done = out_done_reg;

    `RRCS_ASSERT_SAME(a_ring_le_count, clk, rst_n, 1'b1, ring_count_reg <= pcount_reg, "ring holds more entries than the table")
    `RRCS_ASSERT_SAME(a_queued_matches_ring, clk, rst_n, 1'b1, $countones(queued_reg) == ring_count_reg, "queued flags disagree with ring count")
    `RRCS_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, pcount_reg == '0 && ring_count_reg == '0 && comp_reg == '0, "clear left state behind")

endmodule
